// ----- rtl/core/occupancy_grid_ray_update_defines.svh -----
// Assertion macros shared by the occupancy grid ray update RTL.
`ifndef OCCUPANCY_GRID_RAY_UPDATE_DEFINES_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_DEFINES_SVH

`ifndef SYNTHESIS
// Checks that cons holds in the same cycle whenever ante holds.
`define OGRU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Checks that cons holds in the cycle after ante holds.
`define OGRU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OGRU_ASSERT_IMP(label, ante, cons, msg)
`define OGRU_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/core/ogru_pkg.sv -----
// Types and constants shared by the occupancy grid ray update modules.
package ogru_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = 33;
	localparam int SCALE_W = 16;
	localparam int PROD_W  = 50;
	localparam int FRAC_W  = 24;
	localparam int Q_W     = 25;
	localparam int XW      = 26;
	localparam int ERR_W   = 28;
	localparam int CELL_W  = 7;
	localparam int LIMIT_W = 7;
	localparam int STEP_W  = 4;
	localparam int CNT_W   = 8;
	localparam int IDX_W   = 3;

	localparam logic [CELL_W-1:0]  CELL_MAX = 7'd127;
	localparam logic [CNT_W-1:0]   CNT_MAX  = 8'hFF;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd2560;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd100;
	localparam logic [STEP_W-1:0]  STEP_RESET  = 4'd10;

	localparam logic [IDX_W-1:0] REG_ORIGIN_X       = 3'd0;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Y       = 3'd1;
	localparam logic [IDX_W-1:0] REG_CELLS_PER_UNIT = 3'd2;
	localparam logic [IDX_W-1:0] REG_OCCUPIED_LIMIT = 3'd3;
	localparam logic [IDX_W-1:0] REG_HIT_STEP       = 3'd4;

	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CONV1,
		ST_CONV2,
		ST_CONV3,
		ST_SETUP,
		ST_ERR,
		ST_WALK,
		ST_HIT,
		ST_READ_RD,
		ST_READ_DATA,
		ST_DONE
	} walk_state_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] limit;
		logic [STEP_W-1:0]  step;
	} hit_cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0]  cells_freed;
		logic [CELL_W-1:0] cell_value;
		logic              end_in_map;
		logic [7:0]        end_col;
		logic [7:0]        end_row;
	} result_t;

endpackage

// ----- rtl/core/ogru_to_cell.sv -----
// Three-stage conversion of a Q16.16 world coordinate to a signed cell offset.
module ogru_to_cell (
	input  logic                                clk,
	input  logic signed [ogru_pkg::COORD_W-1:0] target,
	input  logic signed [ogru_pkg::COORD_W-1:0] origin,
	input  logic        [ogru_pkg::SCALE_W-1:0] scale,
	output logic signed [ogru_pkg::Q_W-1:0]     cell_ofs
);

	logic signed [ogru_pkg::DIFF_W-1:0] diff_s1;
	logic signed [ogru_pkg::PROD_W-1:0] prod_s2;
	logic signed [ogru_pkg::Q_W-1:0]    cell_s3;
	logic signed [ogru_pkg::PROD_W-1:0] diff_ext;
	logic signed [ogru_pkg::PROD_W-1:0] scale_ext;
	logic signed [ogru_pkg::PROD_W-1:0] bias;
	logic signed [ogru_pkg::PROD_W-1:0] biased;

	assign diff_ext  = ogru_pkg::PROD_W'(diff_s1);
	assign scale_ext = $signed({{(ogru_pkg::PROD_W - ogru_pkg::SCALE_W){1'b0}}, scale});

	// A negative product is biased so that the arithmetic shift truncates toward zero.
	assign bias   = prod_s2[ogru_pkg::PROD_W-1] ?
		ogru_pkg::PROD_W'((64'd1 << ogru_pkg::FRAC_W) - 64'd1) : '0;
	assign biased = prod_s2 + bias;

	always_ff @(posedge clk) begin
		diff_s1 <= {target[ogru_pkg::COORD_W-1], target} - {origin[ogru_pkg::COORD_W-1], origin};
		prod_s2 <= diff_ext * scale_ext;
		cell_s3 <= biased[ogru_pkg::FRAC_W+ogru_pkg::Q_W-1:ogru_pkg::FRAC_W];
	end

	assign cell_ofs = cell_s3;

endmodule

// ----- rtl/core/ogru_walk.sv -----
// Grid memory with the sequencer for clearing, line walking, hit update and cell reads.
`include "occupancy_grid_ray_update_defines.svh"

module ogru_walk #(
	parameter int GRID_SIDE = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              mode,
	input  logic [7:0]                        read_row,
	input  logic [7:0]                        read_col,
	input  logic signed [ogru_pkg::Q_W-1:0]   cell_x,
	input  logic signed [ogru_pkg::Q_W-1:0]   cell_y,
	input  ogru_pkg::hit_cfg_t                cfg,
	input  logic                              res_take,
	output logic                              ready,
	output logic                              res_valid,
	output ogru_pkg::result_t                 res
);

	localparam int IW    = $clog2(GRID_SIDE);
	localparam int PW    = IW + 2;
	localparam int DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int HALF  = GRID_SIDE / 2;

	localparam logic signed [PW-1:0] P_ONE  = PW'(1);
	localparam logic signed [PW-1:0] P_SIDE = PW'(GRID_SIDE);
	localparam logic signed [PW-1:0] P_HALF = PW'(HALF);

	ogru_pkg::walk_state_t state_q, state_d;

	logic [AW-1:0]                      clr_q;
	logic [ogru_pkg::CELL_W-1:0]        grid_mem [DEPTH];
	logic [ogru_pkg::CELL_W-1:0]        rdata_q;
	logic                               mem_we;
	logic [AW-1:0]                      mem_waddr;
	logic [ogru_pkg::CELL_W-1:0]        mem_wdata;
	logic [AW-1:0]                      mem_raddr;

	logic signed [PW-1:0]               x_q, y_q;
	logic signed [ogru_pkg::XW-1:0]     x1_q, y1_q;
	logic signed [ogru_pkg::ERR_W-1:0]  dx_q, dy_q, err_q;
	logic                               sx_q, sy_q;
	logic [ogru_pkg::CNT_W-1:0]         freed_q;
	logic [AW-1:0]                      hit_addr_q;
	ogru_pkg::result_t                  res_q;

	logic signed [ogru_pkg::ERR_W-1:0]  e2;
	logic signed [ogru_pkg::ERR_W-1:0]  err_next;
	logic                               step_x, step_y;
	logic                               in_grid, at_end;
	logic [AW-1:0]                      walk_addr;
	logic [AW-1:0]                      rd_addr;
	logic [IW+7:0]                      row_ext, col_ext, xe, ye;
	logic                               rd_ok;
	logic [7:0]                         hit_sum;
	logic [ogru_pkg::CELL_W-1:0]        hit_val;
	logic                               below;

	assign e2       = {err_q[ogru_pkg::ERR_W-2:0], 1'b0};
	assign step_x   = e2 >= dy_q;
	assign step_y   = e2 <= dx_q;
	assign err_next = err_q + (step_x ? dy_q : '0) + (step_y ? dx_q : '0);

	assign in_grid  = !x_q[PW-1] && (x_q < P_SIDE) && !y_q[PW-1] && (y_q < P_SIDE);
	assign at_end   = (ogru_pkg::XW'(x_q) == x1_q) && (ogru_pkg::XW'(y_q) == y1_q);
	assign walk_addr = AW'(x_q[IW-1:0]) * AW'(GRID_SIDE) + AW'(y_q[IW-1:0]);

	assign row_ext = (IW + 8)'(read_row);
	assign col_ext = (IW + 8)'(read_col);
	assign rd_addr = AW'(row_ext[IW-1:0]) * AW'(GRID_SIDE) + AW'(col_ext[IW-1:0]);
	assign rd_ok   = ({24'd0, read_row} < 32'(GRID_SIDE)) && ({24'd0, read_col} < 32'(GRID_SIDE));

	assign xe = (IW + 8)'(x_q[IW-1:0]);
	assign ye = (IW + 8)'(y_q[IW-1:0]);

	assign below   = rdata_q < cfg.limit;
	assign hit_sum = {1'b0, rdata_q} + {4'd0, cfg.step};
	assign hit_val = (hit_sum > {1'b0, ogru_pkg::CELL_MAX}) ? ogru_pkg::CELL_MAX :
		hit_sum[ogru_pkg::CELL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ogru_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ogru_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = walk_addr;
		mem_wdata = '0;
		mem_raddr = walk_addr;
		ready     = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ogru_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ogru_pkg::ST_IDLE;
				end
			end
			ogru_pkg::ST_IDLE: begin
				ready = 1'b1;
				if (start) begin
					state_d = (mode == ogru_pkg::MODE_READ) ? ogru_pkg::ST_READ_RD :
						ogru_pkg::ST_CONV1;
				end
			end
			ogru_pkg::ST_CONV1: state_d = ogru_pkg::ST_CONV2;
			ogru_pkg::ST_CONV2: state_d = ogru_pkg::ST_CONV3;
			ogru_pkg::ST_CONV3: state_d = ogru_pkg::ST_SETUP;
			ogru_pkg::ST_SETUP: state_d = ogru_pkg::ST_ERR;
			ogru_pkg::ST_ERR:   state_d = ogru_pkg::ST_WALK;
			ogru_pkg::ST_WALK: begin
				if (!in_grid) begin
					state_d = ogru_pkg::ST_DONE;
				end else if (at_end) begin
					state_d = ogru_pkg::ST_HIT;
				end else begin
					mem_we = 1'b1;
				end
			end
			ogru_pkg::ST_HIT: begin
				mem_we    = below;
				mem_waddr = hit_addr_q;
				mem_wdata = hit_val;
				state_d   = ogru_pkg::ST_DONE;
			end
			ogru_pkg::ST_READ_RD: begin
				mem_raddr = rd_addr;
				state_d   = ogru_pkg::ST_READ_DATA;
			end
			ogru_pkg::ST_READ_DATA: state_d = ogru_pkg::ST_DONE;
			ogru_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ogru_pkg::ST_IDLE;
				end
			end
			default: state_d = ogru_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= grid_mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ogru_pkg::ST_SETUP: begin
				x_q     <= P_HALF;
				y_q     <= P_HALF;
				x1_q    <= ogru_pkg::XW'(cell_x) + ogru_pkg::XW'(HALF);
				y1_q    <= ogru_pkg::XW'(cell_y) + ogru_pkg::XW'(HALF);
				dx_q    <= cell_x[ogru_pkg::Q_W-1] ? -ogru_pkg::ERR_W'(cell_x) :
					ogru_pkg::ERR_W'(cell_x);
				dy_q    <= cell_y[ogru_pkg::Q_W-1] ? ogru_pkg::ERR_W'(cell_y) :
					-ogru_pkg::ERR_W'(cell_y);
				sx_q    <= !cell_x[ogru_pkg::Q_W-1] && (cell_x != '0);
				sy_q    <= !cell_y[ogru_pkg::Q_W-1] && (cell_y != '0);
				freed_q <= '0;
			end
			ogru_pkg::ST_ERR: begin
				err_q <= dx_q + dy_q;
			end
			ogru_pkg::ST_WALK: begin
				if (!in_grid) begin
					res_q <= '{cells_freed: freed_q, cell_value: '0, end_in_map: 1'b0,
						end_col: 8'd0, end_row: 8'd0};
				end else if (at_end) begin
					hit_addr_q <= walk_addr;
					res_q      <= '{cells_freed: freed_q, cell_value: '0, end_in_map: 1'b1,
						end_col: ye[7:0], end_row: xe[7:0]};
				end else begin
					if (freed_q != ogru_pkg::CNT_MAX) begin
						freed_q <= freed_q + ogru_pkg::CNT_W'(1);
					end
					err_q <= err_next;
					if (step_x) begin
						x_q <= sx_q ? x_q + P_ONE : x_q - P_ONE;
					end
					if (step_y) begin
						y_q <= sy_q ? y_q + P_ONE : y_q - P_ONE;
					end
				end
			end
			ogru_pkg::ST_HIT: begin
				res_q.cell_value <= below ? hit_val : rdata_q;
			end
			ogru_pkg::ST_READ_DATA: begin
				res_q <= '{cells_freed: '0, cell_value: (rd_ok ? rdata_q : '0),
					end_in_map: 1'b0, end_col: 8'd0, end_row: 8'd0};
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

	`OGRU_ASSERT_IMP(a_hit_below_limit, mem_we && state_q == ogru_pkg::ST_HIT, rdata_q < cfg.limit, "hit written to a cell at or above the occupied limit")
	`OGRU_ASSERT_IMP(a_walk_x_bounds, state_q == ogru_pkg::ST_WALK, x_q >= -P_ONE && x_q <= P_SIDE, "walk x left the one-cell border around the grid")
	`OGRU_ASSERT_IMP(a_walk_y_bounds, state_q == ogru_pkg::ST_WALK, y_q >= -P_ONE && y_q <= P_SIDE, "walk y left the one-cell border around the grid")
	`OGRU_ASSERT_NXT(a_freed_monotonic, state_q == ogru_pkg::ST_WALK && state_d == ogru_pkg::ST_WALK, freed_q >= $past(freed_q), "freed cell count went down during a walk")
	`OGRU_ASSERT_NXT(a_result_held, res_valid && !res_take, res_valid && $stable(res_q), "pending result changed before it was taken")

endmodule

// ----- rtl/core/occupancy_grid_ray_update.sv -----
// Top level of the occupancy grid ray update block with ports and configuration registers.
// After reset the grid is cleared one cell per cycle before the first word is taken;
// configuration writes are taken at all times.
// An update word is converted to cell offsets, set up and walked one freed cell per step, then
// gets a hit update if its end lies inside the grid; a read word reads one cell of the grid.
// Words are handled one at a time; the next word can be taken in the cycle after a result moves to output.
module occupancy_grid_ray_update #(
	parameter int GRID_SIDE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0: target_x[31:0], target_y[63:32], read_row[71:64], read_col[79:72].
	input  logic [79:0] s_tdata,
	// Fields from bit 0: mode.
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0: end_row[7:0], end_col[15:8], end_in_map[16], cell_value[23:17],
	// cells_freed[31:24].
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic signed [ogru_pkg::COORD_W-1:0] origin_x_q, origin_y_q;
	logic [ogru_pkg::SCALE_W-1:0]        scale_q;
	logic [ogru_pkg::LIMIT_W-1:0]        limit_q;
	logic [ogru_pkg::STEP_W-1:0]         step_q;

	logic signed [ogru_pkg::COORD_W-1:0] target_x_q, target_y_q;
	logic [7:0]                          read_row_q, read_col_q;

	logic signed [ogru_pkg::Q_W-1:0]     cell_x, cell_y;
	ogru_pkg::hit_cfg_t                  hit_cfg;
	ogru_pkg::result_t                   res;
	ogru_pkg::result_t                   out_q;
	logic                                res_valid;
	logic                                res_take;
	logic                                out_valid_q;
	logic                                walk_ready;
	logic                                in_accept;

	assign cfg_ready = 1'b1;
	assign s_tready  = walk_ready;
	assign in_accept = s_tvalid && walk_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			scale_q    <= ogru_pkg::SCALE_RESET;
			limit_q    <= ogru_pkg::LIMIT_RESET;
			step_q     <= ogru_pkg::STEP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				ogru_pkg::REG_ORIGIN_X:       origin_x_q <= cfg_data;
				ogru_pkg::REG_ORIGIN_Y:       origin_y_q <= cfg_data;
				ogru_pkg::REG_CELLS_PER_UNIT: scale_q    <= cfg_data[ogru_pkg::SCALE_W-1:0];
				ogru_pkg::REG_OCCUPIED_LIMIT: limit_q    <= cfg_data[ogru_pkg::LIMIT_W-1:0];
				ogru_pkg::REG_HIT_STEP:       step_q     <= cfg_data[ogru_pkg::STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			target_x_q <= s_tdata[31:0];
			target_y_q <= s_tdata[63:32];
			read_row_q <= s_tdata[71:64];
			read_col_q <= s_tdata[79:72];
		end
	end

	assign hit_cfg.limit = limit_q;
	assign hit_cfg.step  = step_q;

	ogru_to_cell u_to_cell_x (
		.clk      (clk),
		.target   (target_x_q),
		.origin   (origin_x_q),
		.scale    (scale_q),
		.cell_ofs (cell_x)
	);

	ogru_to_cell u_to_cell_y (
		.clk      (clk),
		.target   (target_y_q),
		.origin   (origin_y_q),
		.scale    (scale_q),
		.cell_ofs (cell_y)
	);

	ogru_walk #(
		.GRID_SIDE (GRID_SIDE)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_accept),
		.mode      (s_tuser),
		.read_row  (read_row_q),
		.read_col  (read_col_q),
		.cell_x    (cell_x),
		.cell_y    (cell_y),
		.cfg       (hit_cfg),
		.res_take  (res_take),
		.ready     (walk_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	assign res_take = res_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.cells_freed, out_q.cell_value, out_q.end_in_map,
		out_q.end_col, out_q.end_row};

endmodule
